[sv/stereo_downmix_linear_resampler_macros.svh]
// Assertion helpers, clocked on clk_i.
`ifndef STEREO_DOWNMIX_LINEAR_RESAMPLER_MACROS_SVH
`define STEREO_DOWNMIX_LINEAR_RESAMPLER_MACROS_SVH

// Checked only while out of reset.
`define SDLR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SDLR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/sdlr_pkg.sv]
package sdlr_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int STEP_W        = 21;
  localparam int CFG_IDX_W     = 8;
  localparam int STEP_MIN      = 2048;
  localparam int STEP_MAX      = 1048576;
  localparam int STEP_MAX_LOG2 = 20;
  localparam int MAX_RESULTS   = 34;
  localparam int CNT_W         = 6;
  localparam int Q_DEPTH       = 2;
  localparam int PTR_W         = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = CFG_IDX_W'(1);

  // Phase offsets must hold one sample period plus the largest step, and twice that.
  function automatic int ofs_width(int frac_bits);
    return ((frac_bits > STEP_MAX_LOG2) ? frac_bits : STEP_MAX_LOG2) + 2;
  endfunction

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_run;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOOP,
    BK_ADD,
    BK_TAIL,
    BK_FINAL,
    BK_CLOSE
  } bk_state_e;

  typedef struct packed {
    logic idle;
    logic stage_valid;
    logic cnt_zero;
  } bk_status_t;

endpackage

[sv/sdlr_queue.sv]
module sdlr_queue #(
  parameter int DATA_W = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              full_o,
  output logic              empty_o
);

  logic [DATA_W-1:0]            entries_q [sdlr_pkg::Q_DEPTH];
  logic [sdlr_pkg::PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [sdlr_pkg::PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [sdlr_pkg::PTR_W:0]     cnt_q, cnt_d;
  logic                         do_push, do_pop;

  assign full_o     = (cnt_q == (sdlr_pkg::PTR_W+1)'(sdlr_pkg::Q_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/sdlr_front.sv]
module sdlr_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sdlr_pkg::SAMPLE_W-1:0] left_sample_i,
  input  logic signed [sdlr_pkg::SAMPLE_W-1:0] right_sample_i,
  input  logic                                stream_end_i,
  input  logic                                stereo_mode_i,
  input  logic                                pop_i,
  output sdlr_pkg::frame_t                    frame_o,
  output logic                                empty_o
);

  logic signed [sdlr_pkg::SAMPLE_W:0]   mix_sum;
  logic signed [sdlr_pkg::SAMPLE_W:0]   mix_rnd;
  logic signed [sdlr_pkg::SAMPLE_W-1:0] mono;
  sdlr_pkg::frame_t                     frame_in;
  logic                                 q_full;
  logic                                 accept;

  // (l + r) / 2 rounded toward zero: bias negative sums by one before the shift
  assign mix_sum = {left_sample_i[sdlr_pkg::SAMPLE_W-1], left_sample_i}
                 + {right_sample_i[sdlr_pkg::SAMPLE_W-1], right_sample_i};
  assign mix_rnd = mix_sum + {{sdlr_pkg::SAMPLE_W{1'b0}}, mix_sum[sdlr_pkg::SAMPLE_W]};
  assign mono    = stereo_mode_i ? mix_rnd[sdlr_pkg::SAMPLE_W:1] : left_sample_i;

  assign frame_in.sample = mono;
  assign frame_in.last   = stream_end_i;
  assign in_ready_o      = !q_full;
  assign accept          = in_valid_i && in_ready_o;

  sdlr_queue #(
    .DATA_W($bits(sdlr_pkg::frame_t))
  ) u_frame_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (frame_in),
    .pop_i       (pop_i),
    .pop_data_o  (frame_o),
    .full_o      (q_full),
    .empty_o     (empty_o)
  );

endmodule

[sv/sdlr_back.sv]
module sdlr_back #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic [sdlr_pkg::ofs_width(PHASE_FRAC_BITS)-1:0]     eff_step_i,
  input  sdlr_pkg::frame_t                                    frame_i,
  input  logic                                                fifo_empty_i,
  output logic                                                fifo_pop_o,
  output logic                                                out_valid_o,
  input  logic                                                out_ready_i,
  output sdlr_pkg::result_t                                   result_o,
  output sdlr_pkg::bk_status_t                                status_o
);

  localparam int OFS_W  = sdlr_pkg::ofs_width(PHASE_FRAC_BITS);
  localparam int SW     = sdlr_pkg::SAMPLE_W;
  localparam int PROD_W = SW + 2 + PHASE_FRAC_BITS;
  localparam logic [OFS_W-1:0] OnePhase = {{(OFS_W-1){1'b0}}, 1'b1} << PHASE_FRAC_BITS;
  localparam logic [OFS_W-1:0] TwoPhase = OnePhase << 1;

  sdlr_pkg::bk_state_e state_q, state_d;

  logic signed [SW-1:0]     held_q, held_d;
  logic                     have_held_q, have_held_d;
  logic [OFS_W-1:0]         off_q, off_d;
  logic                     emitted_q, emitted_d;
  logic                     pend_valid_q, pend_valid_d;
  logic signed [SW-1:0]     pend_value_q, pend_value_d;
  logic [OFS_W-1:0]         deficit_q, deficit_d;
  logic signed [SW-1:0]     x_q, x_d;
  logic                     last_q, last_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     emit_now_q, emit_now_d;
  logic signed [SW-1:0]     stage_q, stage_d;
  logic                     stage_valid_q, stage_valid_d;
  logic [sdlr_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic signed [SW:0]                diff;
  logic signed [PHASE_FRAC_BITS:0]   frac_s;
  logic [OFS_W-1:0]                  off_sum;
  logic signed [SW-1:0]              interp_v;
  logic                              cnt_below;
  logic                              can_emit, can_flush;
  logic                              emit_req, flush_req, clear_req;
  logic signed [SW-1:0]              emit_val;
  logic                              oq_push, oq_full, oq_empty;
  sdlr_pkg::result_t                 oq_data;

  assign diff      = {x_q[SW-1], x_q} - {held_q[SW-1], held_q};
  assign frac_s    = {1'b0, off_q[PHASE_FRAC_BITS-1:0]};
  assign off_sum   = off_q + eff_step_i;
  // result always lies between the two neighbours, so the 16-bit wrap is exact
  assign interp_v  = held_q + prod_q[PHASE_FRAC_BITS +: SW];
  assign cnt_below = (cnt_q < sdlr_pkg::CNT_W'(sdlr_pkg::MAX_RESULTS));
  // the staged word is pushed on the next emit, so that needs room downstream
  assign can_emit  = !(stage_valid_q && cnt_below) || !oq_full;
  assign can_flush = !stage_valid_q || !oq_full;

  always_comb begin
    state_d       = state_q;
    held_d        = held_q;
    have_held_d   = have_held_q;
    off_d         = off_q;
    emitted_d     = emitted_q;
    pend_valid_d  = pend_valid_q;
    pend_value_d  = pend_value_q;
    deficit_d     = deficit_q;
    x_d           = x_q;
    last_d        = last_q;
    prod_d        = prod_q;
    emit_now_d    = emit_now_q;
    stage_d       = stage_q;
    stage_valid_d = stage_valid_q;
    cnt_d         = cnt_q;
    emit_req      = 1'b0;
    emit_val      = '0;
    flush_req     = 1'b0;
    clear_req     = 1'b0;
    fifo_pop_o    = 1'b0;
    oq_push       = 1'b0;
    oq_data       = '0;

    unique case (state_q)
      sdlr_pkg::BK_IDLE: begin
        if (!fifo_empty_i && can_emit) begin
          fifo_pop_o = 1'b1;
          x_d        = frame_i.sample;
          last_d     = frame_i.last;
          // a held-back output becomes due once enough input has arrived
          if (pend_valid_q) begin
            if (deficit_q <= OnePhase) begin
              emit_req     = 1'b1;
              emit_val     = pend_value_q;
              pend_valid_d = 1'b0;
              deficit_d    = '0;
            end else begin
              deficit_d = deficit_q - OnePhase;
            end
          end
          state_d = sdlr_pkg::BK_LOOP;
        end
      end
      sdlr_pkg::BK_LOOP: begin
        if (have_held_q && (off_q < OnePhase)) begin
          prod_d     = diff * frac_s;
          emit_now_d = (off_sum <= TwoPhase);
          off_d      = off_sum;
          state_d    = sdlr_pkg::BK_ADD;
        end else if (last_q || can_flush) begin
          if (have_held_q) begin
            off_d = off_q - OnePhase;
          end
          held_d      = x_q;
          have_held_d = 1'b1;
          if (last_q) begin
            state_d = sdlr_pkg::BK_TAIL;
          end else begin
            flush_req = 1'b1;
            state_d   = sdlr_pkg::BK_IDLE;
          end
        end
      end
      sdlr_pkg::BK_ADD: begin
        if (emit_now_q) begin
          if (can_emit) begin
            emit_req = 1'b1;
            emit_val = interp_v;
            state_d  = sdlr_pkg::BK_LOOP;
          end
        end else begin
          pend_valid_d = 1'b1;
          pend_value_d = interp_v;
          deficit_d    = off_q - TwoPhase;
          state_d      = sdlr_pkg::BK_LOOP;
        end
      end
      sdlr_pkg::BK_TAIL: begin
        // past the last sample the right neighbour repeats the left
        if ((off_q < OnePhase) && (off_sum <= OnePhase)) begin
          if (can_emit) begin
            emit_req = 1'b1;
            emit_val = held_q;
            off_d    = off_sum;
          end
        end else begin
          state_d = sdlr_pkg::BK_FINAL;
        end
      end
      sdlr_pkg::BK_FINAL: begin
        if (!emitted_q) begin
          if (can_emit) begin
            emit_req  = 1'b1;
            emit_val  = pend_valid_q ? pend_value_q : held_q;
            clear_req = 1'b1;
            state_d   = sdlr_pkg::BK_CLOSE;
          end
        end else begin
          clear_req = 1'b1;
          state_d   = sdlr_pkg::BK_CLOSE;
        end
      end
      sdlr_pkg::BK_CLOSE: begin
        if (can_flush) begin
          flush_req = 1'b1;
          state_d   = sdlr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = sdlr_pkg::BK_IDLE;
      end
    endcase

    // one word is staged so the last word of a frame can carry end_of_run
    if (emit_req) begin
      emitted_d = 1'b1;
      if (cnt_below) begin
        cnt_d = cnt_q + 1'b1;
        if (stage_valid_q) begin
          oq_push            = 1'b1;
          oq_data.sample     = stage_q;
          oq_data.end_of_run = 1'b0;
        end
        stage_d       = emit_val;
        stage_valid_d = 1'b1;
      end
    end
    if (flush_req) begin
      if (stage_valid_q) begin
        oq_push            = 1'b1;
        oq_data.sample     = stage_q;
        oq_data.end_of_run = 1'b1;
      end
      stage_valid_d = 1'b0;
      cnt_d         = '0;
    end
    if (clear_req) begin
      held_d       = '0;
      have_held_d  = 1'b0;
      off_d        = '0;
      emitted_d    = 1'b0;
      pend_valid_d = 1'b0;
      pend_value_d = '0;
      deficit_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= sdlr_pkg::BK_IDLE;
      held_q        <= '0;
      have_held_q   <= 1'b0;
      off_q         <= '0;
      emitted_q     <= 1'b0;
      pend_valid_q  <= 1'b0;
      pend_value_q  <= '0;
      deficit_q     <= '0;
      last_q        <= 1'b0;
      emit_now_q    <= 1'b0;
      stage_valid_q <= 1'b0;
      cnt_q         <= '0;
    end else begin
      state_q       <= state_d;
      held_q        <= held_d;
      have_held_q   <= have_held_d;
      off_q         <= off_d;
      emitted_q     <= emitted_d;
      pend_valid_q  <= pend_valid_d;
      pend_value_q  <= pend_value_d;
      deficit_q     <= deficit_d;
      last_q        <= last_d;
      emit_now_q    <= emit_now_d;
      stage_valid_q <= stage_valid_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    prod_q  <= prod_d;
    stage_q <= stage_d;
  end

  sdlr_queue #(
    .DATA_W($bits(sdlr_pkg::result_t))
  ) u_out_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (oq_push),
    .push_data_i (oq_data),
    .pop_i       (out_ready_i),
    .pop_data_o  (result_o),
    .full_o      (oq_full),
    .empty_o     (oq_empty)
  );

  assign out_valid_o          = !oq_empty;
  assign status_o.idle        = (state_q == sdlr_pkg::BK_IDLE);
  assign status_o.stage_valid = stage_valid_q;
  assign status_o.cnt_zero    = (cnt_q == '0);

endmodule

[sv/stereo_downmix_linear_resampler.sv]
// Sequencing: the back end pops a frame only from idle, then spends a multiply step and an add
// step on each interpolated word and closes the frame with a flush; a full output queue stalls
// it. Tail words of a final frame are emitted from the tail state, then the final and close
// states end the clip.
// Reset: rst_ni is asynchronous, active low; it empties both queues, clears the stream state,
// sets the step to 1.0 (clamped to range) and selects mono input.
`include "stereo_downmix_linear_resampler_macros.svh"

module stereo_downmix_linear_resampler #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [sdlr_pkg::SAMPLE_W-1:0]  left_sample_i,
  input  logic signed [sdlr_pkg::SAMPLE_W-1:0]  right_sample_i,
  input  logic                                  stream_end_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [sdlr_pkg::SAMPLE_W-1:0]  out_sample_o,
  output logic                                  end_of_run_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sdlr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sdlr_pkg::STEP_W-1:0]           cfg_data_i
);

  localparam int OFS_W = sdlr_pkg::ofs_width(PHASE_FRAC_BITS);
  localparam logic [OFS_W-1:0] OnePhase = {{(OFS_W-1){1'b0}}, 1'b1} << PHASE_FRAC_BITS;
  localparam logic [OFS_W-1:0] StepMin  = OFS_W'(sdlr_pkg::STEP_MIN);
  localparam logic [OFS_W-1:0] StepMax  = OFS_W'(sdlr_pkg::STEP_MAX);
  localparam logic [OFS_W-1:0] EffReset = (OnePhase < StepMin) ? StepMin :
                                          (OnePhase > StepMax) ? StepMax : OnePhase;

  logic [OFS_W-1:0]     eff_step_q, eff_step_d;
  logic                 stereo_q, stereo_d;
  logic [OFS_W-1:0]     wr_step;
  sdlr_pkg::frame_t     frame;
  logic                 frame_empty, frame_pop;
  sdlr_pkg::result_t    result;
  sdlr_pkg::bk_status_t bk_status;
  logic                 step_ok, zero_step_wr, idle_clean;

  assign cfg_ready_o = 1'b1;
  assign wr_step     = {{(OFS_W-sdlr_pkg::STEP_W){1'b0}}, cfg_data_i};

  // the step is stored already clamped; zero means exactly one sample
  always_comb begin
    eff_step_d = eff_step_q;
    stereo_d   = stereo_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sdlr_pkg::REG_PHASE_STEP: begin
          if (wr_step == '0) begin
            eff_step_d = OnePhase;
          end else if (wr_step < StepMin) begin
            eff_step_d = StepMin;
          end else if (wr_step > StepMax) begin
            eff_step_d = StepMax;
          end else begin
            eff_step_d = wr_step;
          end
        end
        sdlr_pkg::REG_STEREO_MODE: begin
          stereo_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_step_q <= EffReset;
      stereo_q   <= 1'b0;
    end else begin
      eff_step_q <= eff_step_d;
      stereo_q   <= stereo_d;
    end
  end

  sdlr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .stream_end_i   (stream_end_i),
    .stereo_mode_i  (stereo_q),
    .pop_i          (frame_pop),
    .frame_o        (frame),
    .empty_o        (frame_empty)
  );

  sdlr_back #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eff_step_i   (eff_step_q),
    .frame_i      (frame),
    .fifo_empty_i (frame_empty),
    .fifo_pop_o   (frame_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result),
    .status_o     (bk_status)
  );

  assign out_sample_o = result.sample;
  assign end_of_run_o = result.end_of_run;

  assign step_ok      = (eff_step_q == OnePhase) ||
                        ((eff_step_q >= StepMin) && (eff_step_q <= StepMax));
  assign zero_step_wr = cfg_valid_i && cfg_ready_o &&
                        (cfg_index_i == sdlr_pkg::REG_PHASE_STEP) && (cfg_data_i == '0);
  assign idle_clean   = !bk_status.stage_valid && bk_status.cnt_zero;

  `SDLR_ASSERT(a_step_in_range, step_ok, "effective step outside its range")
  `SDLR_ASSERT(a_zero_unity, zero_step_wr |=> (eff_step_q == OnePhase), "zero step not unity")
  `SDLR_ASSERT(a_idle_no_stage, bk_status.idle |-> idle_clean, "back end idle with a word staged")
  `SDLR_ASSERT_ALWAYS(a_reset_step, $rose(rst_ni) |-> (eff_step_q == EffReset), "step not reset")

endmodule
